// ----- hw/rtl/ptd_pkg.sv -----
// ----------------------------------------------------------------------------
// ptd_pkg
// Shared types and constants of the point-to-triangle squared distance pipe.
// ----------------------------------------------------------------------------
package ptd_pkg;

  localparam int MUL_CHUNK = 32;
  localparam int MUL_LAT   = 3;

  typedef enum logic [2:0] {
    REG_A,
    REG_B,
    REG_C,
    REG_AB,
    REG_AC,
    REG_BC,
    REG_FACE
  } region_t;

  typedef struct packed {
    logic vert_a;
    logic vert_b;
    logic vert_c;
    logic edge_ab;
    logic edge_ac;
    logic edge_bc;
  } reg_flags_t;

endpackage

// ----- hw/rtl/ptd_mul.sv -----
// ----------------------------------------------------------------------------
// ptd_mul
// Pipelined signed multiplier built from chunk partial products: partial
// products, row sums and final sum, one register each.
// ----------------------------------------------------------------------------
module ptd_mul #(
  parameter int AW = 32,
  parameter int BW = 32
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [AW-1:0]     a,
  input  logic signed [BW-1:0]     b,
  output logic signed [AW+BW-1:0]  prod
);
  import ptd_pkg::*;

  localparam int C   = MUL_CHUNK;
  localparam int NA  = (AW + C - 1) / C;
  localparam int NB  = (BW + C - 1) / C;
  localparam int AXW = NA * C;
  localparam int BXW = NB * C;
  localparam int PW  = AW + BW;
  localparam int XW  = (PW > 2 * C + 2) ? PW : 2 * C + 2;

  logic signed [AXW-1:0]   a_ext;
  logic signed [BXW-1:0]   b_ext;
  logic signed [C:0]       a_chk [NA];
  logic signed [C:0]       b_chk [NB];
  logic signed [2*C+1:0]   pp_r [NA][NB];
  logic signed [2*C+1:0]   pp_nxt [NA][NB];
  logic signed [PW-1:0]    row_r [NA];
  logic signed [PW-1:0]    row_nxt [NA];
  logic signed [PW-1:0]    prod_r;
  logic signed [PW-1:0]    prod_nxt;
  logic signed [XW-1:0]    pp_ext;

  always_comb begin
    a_ext = AXW'(a);
    b_ext = BXW'(b);
    for (int i = 0; i < NA; i++) begin
      if (i == NA - 1) begin
        a_chk[i] = {a_ext[i*C+C-1], a_ext[i*C +: C]};
      end else begin
        a_chk[i] = {1'b0, a_ext[i*C +: C]};
      end
    end
    for (int j = 0; j < NB; j++) begin
      if (j == NB - 1) begin
        b_chk[j] = {b_ext[j*C+C-1], b_ext[j*C +: C]};
      end else begin
        b_chk[j] = {1'b0, b_ext[j*C +: C]};
      end
    end
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        pp_nxt[i][j] = a_chk[i] * b_chk[j];
      end
    end
  end

  always_comb begin
    pp_ext = '0;
    for (int i = 0; i < NA; i++) begin
      row_nxt[i] = '0;
      for (int j = 0; j < NB; j++) begin
        pp_ext     = XW'(pp_r[i][j]);
        row_nxt[i] = row_nxt[i] + (pp_ext[PW-1:0] << (C * j));
      end
    end
    prod_nxt = '0;
    for (int i = 0; i < NA; i++) begin
      prod_nxt = prod_nxt + (row_r[i] << (C * i));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pp_r   <= pp_nxt;
      row_r  <= row_nxt;
      prod_r <= prod_nxt;
    end
  end

  assign prod = prod_r;

endmodule

// ----- hw/rtl/ptd_front.sv -----
// ----------------------------------------------------------------------------
// ptd_front
// Edge and offset vectors, their products, then the dot products, squared
// lengths and face normal components.
// ----------------------------------------------------------------------------
module ptd_front #(
  parameter int CW = 24
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [CW-1:0]    pnt   [3],
  input  logic signed [CW-1:0]    crn_a [3],
  input  logic signed [CW-1:0]    crn_b [3],
  input  logic signed [CW-1:0]    crn_c [3],
  output logic signed [2*CW+3:0]  dot   [9],
  output logic signed [2*CW+3:0]  nrm   [3],
  output logic signed [CW:0]      apd   [3]
);

  localparam int EW = CW + 1;
  localparam int PW = 2 * EW;
  localparam int DW = 2 * CW + 4;

  logic signed [EW-1:0] ab_r [3], ab_nxt [3];
  logic signed [EW-1:0] ac_r [3], ac_nxt [3];
  logic signed [EW-1:0] ap_r [3], ap_nxt [3];
  logic signed [EW-1:0] bp_r [3], bp_nxt [3];
  logic signed [EW-1:0] cp_r [3], cp_nxt [3];
  logic signed [EW-1:0] ap2_r [3];
  logic signed [EW-1:0] ap3_r [3];
  logic signed [PW-1:0] pr_r [9][3], pr_nxt [9][3];
  logic signed [PW-1:0] cr_r [3][2], cr_nxt [3][2];
  logic signed [DW-1:0] dot_r [9], dot_nxt [9];
  logic signed [DW-1:0] nrm_r [3], nrm_nxt [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ab_nxt[k] = EW'(crn_b[k]) - EW'(crn_a[k]);
      ac_nxt[k] = EW'(crn_c[k]) - EW'(crn_a[k]);
      ap_nxt[k] = EW'(pnt[k]) - EW'(crn_a[k]);
      bp_nxt[k] = EW'(pnt[k]) - EW'(crn_b[k]);
      cp_nxt[k] = EW'(pnt[k]) - EW'(crn_c[k]);
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pr_nxt[0][k] = ab_r[k] * ap_r[k];
      pr_nxt[1][k] = ac_r[k] * ap_r[k];
      pr_nxt[2][k] = ab_r[k] * bp_r[k];
      pr_nxt[3][k] = ac_r[k] * bp_r[k];
      pr_nxt[4][k] = ab_r[k] * cp_r[k];
      pr_nxt[5][k] = ac_r[k] * cp_r[k];
      pr_nxt[6][k] = ap_r[k] * ap_r[k];
      pr_nxt[7][k] = bp_r[k] * bp_r[k];
      pr_nxt[8][k] = cp_r[k] * cp_r[k];
    end
    cr_nxt[0][0] = ab_r[1] * ac_r[2];
    cr_nxt[0][1] = ab_r[2] * ac_r[1];
    cr_nxt[1][0] = ab_r[2] * ac_r[0];
    cr_nxt[1][1] = ab_r[0] * ac_r[2];
    cr_nxt[2][0] = ab_r[0] * ac_r[1];
    cr_nxt[2][1] = ab_r[1] * ac_r[0];
  end

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      dot_nxt[i] = DW'(pr_r[i][0]) + DW'(pr_r[i][1]) + DW'(pr_r[i][2]);
    end
    for (int k = 0; k < 3; k++) begin
      nrm_nxt[k] = DW'(cr_r[k][0]) - DW'(cr_r[k][1]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ab_r  <= ab_nxt;
      ac_r  <= ac_nxt;
      ap_r  <= ap_nxt;
      bp_r  <= bp_nxt;
      cp_r  <= cp_nxt;
      pr_r  <= pr_nxt;
      cr_r  <= cr_nxt;
      ap2_r <= ap_r;
      dot_r <= dot_nxt;
      nrm_r <= nrm_nxt;
      ap3_r <= ap2_r;
    end
  end

  assign dot = dot_r;
  assign nrm = nrm_r;
  assign apd = ap3_r;

endmodule

// ----- hw/rtl/ptd_region.sv -----
// ----------------------------------------------------------------------------
// ptd_region
// Barycentric terms, region classification and selection of the numerator
// and divisor that give the squared distance of the region.
// ----------------------------------------------------------------------------
module ptd_region #(
  parameter int CW = 24
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [2*CW+3:0]        dot [9],
  input  logic signed [2*CW+3:0]        nrm [3],
  input  logic signed [CW:0]            apd [3],
  output logic [2*(3*CW+7)-1:0]         num,
  output logic [2*(2*CW+4)+1:0]         dvs
);
  import ptd_pkg::*;

  localparam int EW  = CW + 1;
  localparam int DW  = 2 * CW + 4;
  localparam int EDW = DW + 2;
  localparam int VW  = 2 * DW + 2;
  localparam int SW  = DW + EW + 2;
  localparam int NW  = 2 * SW;

  localparam int VMA [6] = '{0, 2, 4, 0, 2, 3};
  localparam int VMB [6] = '{3, 1, 1, 5, 5, 4};

  typedef struct packed {
    reg_flags_t            flg;
    logic signed [DW-1:0]  la;
    logic signed [DW-1:0]  lb;
    logic signed [DW-1:0]  lc;
    logic signed [DW-1:0]  ta;
    logic signed [DW-1:0]  tb;
    logic signed [EDW-1:0] tc;
    logic signed [EDW-1:0] eab;
    logic signed [EDW-1:0] eac;
    logic signed [EDW-1:0] ebc;
  } side_t;

  side_t                  side_nxt;
  side_t                  side_r [MUL_LAT];
  side_t                  side7_r;
  side_t                  side8_r;
  logic signed [2*DW-1:0] pv [6];
  logic signed [DW+EW-1:0] ps [3];
  logic signed [VW-1:0]   vsa_r, vsa_nxt, vsb_r, vsb_nxt, vsc_r, vsc_nxt;
  logic signed [SW-1:0]   s_r, s_nxt, s8_r;
  logic signed [VW-1:0]   den_r, den_nxt;
  region_t                rgn_r, rgn_nxt;
  reg_flags_t             fl;
  logic signed [SW-1:0]   x_r, x_nxt, y_r, y_nxt, t_r, t_nxt;
  logic [VW-1:0]          dv_r, dv_nxt;
  logic [VW-1:0]          dvq_r [MUL_LAT];
  logic signed [NW-1:0]   xy, tt;
  logic [NW-1:0]          num_r, num_nxt;
  logic [VW-1:0]          dvo_r;

  for (genvar g = 0; g < 6; g++) begin : g_vmul
    ptd_mul #(.AW(DW), .BW(DW)) u_mul (
      .clk  (clk),
      .en   (en),
      .a    (dot[VMA[g]]),
      .b    (dot[VMB[g]]),
      .prod (pv[g])
    );
  end

  for (genvar g = 0; g < 3; g++) begin : g_smul
    ptd_mul #(.AW(DW), .BW(EW)) u_mul (
      .clk  (clk),
      .en   (en),
      .a    (nrm[g]),
      .b    (apd[g]),
      .prod (ps[g])
    );
  end

  always_comb begin
    side_nxt.flg.vert_a  = (dot[0] <= 0) && (dot[1] <= 0);
    side_nxt.flg.vert_b  = (dot[2] >= 0) && (dot[3] <= dot[2]);
    side_nxt.flg.vert_c  = (dot[5] >= 0) && (dot[4] <= dot[5]);
    side_nxt.flg.edge_ab = (dot[0] >= 0) && (dot[2] <= 0);
    side_nxt.flg.edge_ac = (dot[1] >= 0) && (dot[5] <= 0);
    side_nxt.flg.edge_bc = (dot[3] >= dot[2]) && (dot[4] >= dot[5]);
    side_nxt.la  = dot[6];
    side_nxt.lb  = dot[7];
    side_nxt.lc  = dot[8];
    side_nxt.ta  = dot[0];
    side_nxt.tb  = dot[1];
    side_nxt.tc  = EDW'(dot[3]) - EDW'(dot[2]);
    side_nxt.eab = EDW'(dot[0]) - EDW'(dot[2]);
    side_nxt.eac = EDW'(dot[1]) - EDW'(dot[5]);
    side_nxt.ebc = EDW'(dot[3]) - EDW'(dot[2]) + EDW'(dot[4]) - EDW'(dot[5]);
  end

  always_comb begin
    vsc_nxt = VW'(pv[0]) - VW'(pv[1]);
    vsb_nxt = VW'(pv[2]) - VW'(pv[3]);
    vsa_nxt = VW'(pv[4]) - VW'(pv[5]);
    s_nxt   = SW'(ps[0]) + SW'(ps[1]) + SW'(ps[2]);
  end

  always_comb begin
    fl      = side7_r.flg;
    den_nxt = vsa_r + vsb_r + vsc_r;
    if (fl.vert_a) begin
      rgn_nxt = REG_A;
    end else if (fl.vert_b) begin
      rgn_nxt = REG_B;
    end else if (fl.vert_c) begin
      rgn_nxt = REG_C;
    end else if ((vsc_r <= 0) && fl.edge_ab) begin
      rgn_nxt = REG_AB;
    end else if ((vsb_r <= 0) && fl.edge_ac) begin
      rgn_nxt = REG_AC;
    end else if ((vsa_r <= 0) && fl.edge_bc) begin
      rgn_nxt = REG_BC;
    end else begin
      rgn_nxt = REG_FACE;
    end
  end

  always_comb begin
    x_nxt  = SW'($signed(side8_r.la));
    y_nxt  = SW'(1);
    t_nxt  = '0;
    dv_nxt = VW'(1);
    unique case (rgn_r)
      REG_A: x_nxt = SW'($signed(side8_r.la));
      REG_B: x_nxt = SW'($signed(side8_r.lb));
      REG_C: x_nxt = SW'($signed(side8_r.lc));
      REG_AB: begin
        if (side8_r.eab != '0) begin
          y_nxt  = SW'($signed(side8_r.eab));
          t_nxt  = SW'($signed(side8_r.ta));
          dv_nxt = VW'($signed(side8_r.eab));
        end
      end
      REG_AC: begin
        if (side8_r.eac != '0) begin
          y_nxt  = SW'($signed(side8_r.eac));
          t_nxt  = SW'($signed(side8_r.tb));
          dv_nxt = VW'($signed(side8_r.eac));
        end
      end
      REG_BC: begin
        x_nxt = SW'($signed(side8_r.lb));
        if (side8_r.ebc != '0) begin
          y_nxt  = SW'($signed(side8_r.ebc));
          t_nxt  = SW'($signed(side8_r.tc));
          dv_nxt = VW'($signed(side8_r.ebc));
        end
      end
      REG_FACE: begin
        if (den_r != '0) begin
          x_nxt  = s8_r;
          y_nxt  = s8_r;
          dv_nxt = den_r;
        end
      end
      default: ;
    endcase
  end

  ptd_mul #(.AW(SW), .BW(SW)) u_mul_xy (
    .clk  (clk),
    .en   (en),
    .a    (x_r),
    .b    (y_r),
    .prod (xy)
  );

  ptd_mul #(.AW(SW), .BW(SW)) u_mul_tt (
    .clk  (clk),
    .en   (en),
    .a    (t_r),
    .b    (t_r),
    .prod (tt)
  );

  assign num_nxt = xy - tt;

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side_nxt;
      for (int k = 1; k < MUL_LAT; k++) begin
        side_r[k] <= side_r[k-1];
      end
      side7_r  <= side_r[MUL_LAT-1];
      vsa_r    <= vsa_nxt;
      vsb_r    <= vsb_nxt;
      vsc_r    <= vsc_nxt;
      s_r      <= s_nxt;
      side8_r  <= side7_r;
      s8_r     <= s_r;
      den_r    <= den_nxt;
      rgn_r    <= rgn_nxt;
      x_r      <= x_nxt;
      y_r      <= y_nxt;
      t_r      <= t_nxt;
      dv_r     <= dv_nxt;
      dvq_r[0] <= dv_r;
      for (int k = 1; k < MUL_LAT; k++) begin
        dvq_r[k] <= dvq_r[k-1];
      end
      num_r    <= num_nxt;
      dvo_r    <= dvq_r[MUL_LAT-1];
    end
  end

  assign num = num_r;
  assign dvs = dvo_r;

endmodule

// ----- hw/rtl/ptd_div.sv -----
// ----------------------------------------------------------------------------
// ptd_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module ptd_div #(
  parameter int NW = 158,
  parameter int VW = 108,
  parameter int QB = 50
) (
  input  logic           clk,
  input  logic           en,
  input  logic [NW-1:0]  num,
  input  logic [VW-1:0]  dvs,
  output logic [QB-1:0]  quo
);

  logic [VW-1:0] rem_in [QB], rem_r [QB], rem_nxt [QB];
  logic [VW-1:0] dvs_in [QB], dvs_r [QB];
  logic [QB-1:0] low_in [QB], low_r [QB], low_nxt [QB];
  logic [QB-1:0] quo_in [QB], quo_r [QB], quo_nxt [QB];
  logic [VW:0]   trial [QB];

  always_comb begin
    rem_in[0] = VW'(num >> QB);
    low_in[0] = num[QB-1:0];
    quo_in[0] = '0;
    dvs_in[0] = dvs;
    for (int i = 1; i < QB; i++) begin
      rem_in[i] = rem_r[i-1];
      low_in[i] = low_r[i-1];
      quo_in[i] = quo_r[i-1];
      dvs_in[i] = dvs_r[i-1];
    end
    for (int i = 0; i < QB; i++) begin
      trial[i]   = {rem_in[i], low_in[i][QB-1]};
      low_nxt[i] = low_in[i] << 1;
      if (trial[i] >= {1'b0, dvs_in[i]}) begin
        rem_nxt[i] = VW'(trial[i] - {1'b0, dvs_in[i]});
        quo_nxt[i] = {quo_in[i][QB-2:0], 1'b1};
      end else begin
        rem_nxt[i] = trial[i][VW-1:0];
        quo_nxt[i] = {quo_in[i][QB-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      low_r <= low_nxt;
      quo_r <= quo_nxt;
      dvs_r <= dvs_in;
    end
  end

  assign quo = quo_r[QB-1];

endmodule

// ----- hw/rtl/point_triangle_distance_squared_top.sv -----
// ----------------------------------------------------------------------------
// point_triangle_distance_squared_top
// Throughput: one point-triangle pair per cycle; the final divider stage
// holds the result, and a stalled result holds every stage in place.
// Reset clears the valid pipeline only; no other state.
// Exact squared distance from a point to a triangle, floored.
// ----------------------------------------------------------------------------
module point_triangle_distance_squared_top #(
  parameter int COORD_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_BITS-1:0]  in_point_x,
  input  logic signed [COORD_BITS-1:0]  in_point_y,
  input  logic signed [COORD_BITS-1:0]  in_point_z,
  input  logic signed [COORD_BITS-1:0]  in_vert_a_x,
  input  logic signed [COORD_BITS-1:0]  in_vert_a_y,
  input  logic signed [COORD_BITS-1:0]  in_vert_a_z,
  input  logic signed [COORD_BITS-1:0]  in_vert_b_x,
  input  logic signed [COORD_BITS-1:0]  in_vert_b_y,
  input  logic signed [COORD_BITS-1:0]  in_vert_b_z,
  input  logic signed [COORD_BITS-1:0]  in_vert_c_x,
  input  logic signed [COORD_BITS-1:0]  in_vert_c_y,
  input  logic signed [COORD_BITS-1:0]  in_vert_c_z,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [2*COORD_BITS+1:0]       out_dist_squared
);
  import ptd_pkg::*;

  localparam int CW  = COORD_BITS;
  localparam int EW  = CW + 1;
  localparam int DW  = 2 * CW + 4;
  localparam int VW  = 2 * DW + 2;
  localparam int SW  = DW + EW + 2;
  localparam int NW  = 2 * SW;
  localparam int OW  = 2 * CW + 2;
  localparam int LAT = 3 + 2 * MUL_LAT + 4 + OW;

  logic                 en;
  logic [LAT-1:0]       vld_r, vld_nxt;
  logic signed [CW-1:0] pnt [3], crn_a [3], crn_b [3], crn_c [3];
  logic signed [DW-1:0] dot [9];
  logic signed [DW-1:0] nrm [3];
  logic signed [EW-1:0] apd [3];
  logic [NW-1:0]        num;
  logic [VW-1:0]        dvs;

  assign en       = !vld_r[LAT-1] || out_ready;
  assign in_ready = en && rst_n;
  assign vld_nxt  = {vld_r[LAT-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  assign pnt[0]   = in_point_x;
  assign pnt[1]   = in_point_y;
  assign pnt[2]   = in_point_z;
  assign crn_a[0] = in_vert_a_x;
  assign crn_a[1] = in_vert_a_y;
  assign crn_a[2] = in_vert_a_z;
  assign crn_b[0] = in_vert_b_x;
  assign crn_b[1] = in_vert_b_y;
  assign crn_b[2] = in_vert_b_z;
  assign crn_c[0] = in_vert_c_x;
  assign crn_c[1] = in_vert_c_y;
  assign crn_c[2] = in_vert_c_z;

  ptd_front #(.CW(CW)) u_front (
    .clk   (clk),
    .en    (en),
    .pnt   (pnt),
    .crn_a (crn_a),
    .crn_b (crn_b),
    .crn_c (crn_c),
    .dot   (dot),
    .nrm   (nrm),
    .apd   (apd)
  );

  ptd_region #(.CW(CW)) u_region (
    .clk (clk),
    .en  (en),
    .dot (dot),
    .nrm (nrm),
    .apd (apd),
    .num (num),
    .dvs (dvs)
  );

  ptd_div #(.NW(NW), .VW(VW), .QB(OW)) u_div (
    .clk (clk),
    .en  (en),
    .num (num),
    .dvs (dvs),
    .quo (out_dist_squared)
  );

  assign out_valid = vld_r[LAT-1];

endmodule
